@@ rtl/hsla_pkg.sv @@
// shared types, register codes and helper functions for the rgb/hsl color adjust block
// no dependencies; used by rgb_hsl_color_adjust through scoped names
package hsla_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_HUE_SHIFT  = 2'd0,
		REG_SAT_OFFSET = 2'd1,
		REG_LIGHT_GAIN = 2'd2
	} cfg_reg_t;

	// hue sector of one output channel
	typedef enum logic [1:0] {
		SEC_RISE = 2'd0,
		SEC_HIGH = 2'd1,
		SEC_FALL = 2'd2,
		SEC_LOW  = 2'd3
	} sector_t;

	localparam int DEG_TURN = 360;
	localparam logic [7:0] CH_MAX = 8'd255;

	// reduce a signed 10-bit degree count into 0..359
	function automatic logic [8:0] hue_mod(input logic [9:0] deg);
		logic [10:0] x;
		begin
			x = {deg[9], deg} + 11'd720;
			for (int i = 0; i < 3; i++) begin
				if (x >= 11'(DEG_TURN)) x = x - 11'(DEG_TURN);
			end
			return x[8:0];
		end
	endfunction

endpackage

@@ rtl/hsla_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// computes floor(numer * 2^(QB-1) / denom) for numer < 2*denom; uses no package
module hsla_div #(
	parameter int QB = 17,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic [DW:0]   numer,
	input  logic [DW-1:0] denom,
	output logic [QB-1:0] quot,
	output logic          rem_nz
);

	localparam int RW = DW + 1;

	logic [RW-1:0] rem_q [QB];
	logic [QB-1:0] quo_q [QB];
	logic [DW-1:0] den_q [QB];

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [RW-1:0] rr;
		logic [QB-1:0] qin;
		logic [DW-1:0] din;
		logic          ge;

		// partial remainder entering this step
		if (j == 0) begin : g_first
			assign rr  = numer;
			assign qin = '0;
			assign din = denom;
		end else begin : g_next
			assign rr  = {rem_q[j-1][RW-2:0], 1'b0};
			assign qin = quo_q[j-1];
			assign din = den_q[j-1];
		end

		assign ge = rr >= {1'b0, din};

		// compare and subtract, one quotient bit
		always_ff @(posedge clk) begin
			rem_q[j] <= ge ? rr - {1'b0, din} : rr;
			quo_q[j] <= qin | (ge ? (QB'(1) << (QB - 1 - j)) : QB'(0));
			den_q[j] <= din;
		end
	end

	assign quot   = quo_q[QB-1];
	assign rem_nz = |rem_q[QB-1];

endmodule

@@ rtl/rgb_hsl_color_adjust.sv @@
// rgba pixel color adjust in hsl space: hue rotate, saturation offset, lightness gain
// depends on hsla_pkg and hsla_div
//
// channel   direction  handshake           payload
// pixel in  in         start / busy        in_red in_green in_blue in_alpha
// pixel out out        strobe              out_red out_green out_blue out_alpha
// config    in         cfg_valid/cfg_ready cfg_index cfg_data
//
// one pixel per clock; each item passes through the four front stages,
// the FRAC_BITS + 1 stage pipelined dividers for hue and saturation
// and nine back stages of hsl to rgb math.
// busy stays low: the pipeline never stalls, results are shown for one cycle.
// reset clears valid bits and restores the register defaults; payload is not reset.
module rgb_hsl_color_adjust #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_alpha,
	output logic        strobe,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int F     = FRAC_BITS;
	localparam int QB    = F + 1;
	localparam int DL    = QB + 8;
	localparam int ONE_I = 1 << F;
	localparam logic [F:0]   ONE   = (F+1)'(ONE_I);
	localparam logic [F-1:0] THIRD = F'(ONE_I / 3);
	localparam logic [F-1:0] TWO_THIRD = F'(ONE_I - ONE_I / 3);
	// lightness is sum * 2^(F-1) / 255, split into sum * L_QA + sum * L_RA / 255
	localparam int LA_I = 1 << (F - 1);
	localparam logic [F:0] L_QA = (F+1)'(LA_I / 255);
	localparam logic [7:0] L_RA = 8'(LA_I % 255);

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	logic [8:0]  hue_q;
	logic [9:0]  sat_q;
	logic [10:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q  <= '0;
			sat_q  <= '0;
			gain_q <= 11'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (hsla_pkg::cfg_reg_t'(cfg_index))
				hsla_pkg::REG_HUE_SHIFT:  hue_q  <= hsla_pkg::hue_mod(cfg_data[9:0]);
				hsla_pkg::REG_SAT_OFFSET: sat_q  <= cfg_data[9:0];
				hsla_pkg::REG_LIGHT_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: input registers
	logic       vld_s1;
	logic [7:0] r_s1, g_s1, b_s1, a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		r_s1 <= in_red;
		g_s1 <= in_green;
		b_s1 <= in_blue;
		a_s1 <= in_alpha;
	end

	// s2: max, min, spread and hue numerator
	logic [7:0]         mx_c, mn_c, dl_c;
	logic signed [11:0] num_c;
	logic               vld_s2;
	logic [7:0]         delta_s2, dd_s2, a_s2;
	logic [8:0]         sum_s2;
	logic signed [11:0] num_s2;

	always_comb begin
		mx_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		mn_c = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
		dl_c = mx_c - mn_c;
		if (dl_c == 8'd0)
			num_c = '0;
		else if (r_s1 == mx_c)
			num_c = $signed({4'b0, g_s1}) - $signed({4'b0, b_s1});
		else if (g_s1 == mx_c)
			num_c = $signed({3'b0, dl_c, 1'b0}) + $signed({4'b0, b_s1})
				- $signed({4'b0, r_s1});
		else
			num_c = $signed({2'b0, dl_c, 2'b0}) + $signed({4'b0, r_s1})
				- $signed({4'b0, g_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		delta_s2 <= dl_c;
		dd_s2    <= (dl_c == 8'd0) ? 8'd1 : dl_c;
		sum_s2   <= {1'b0, mx_c} + {1'b0, mn_c};
		num_s2   <= num_c;
		a_s2     <= a_s1;
	end

	// s3: hue numerator with shift, turn size, saturation divisor, lightness parts
	logic               vld_s3;
	logic signed [18:0] np_s3;
	logic [16:0]        d_s3;
	logic [7:0]         snum_s3, a_s3;
	logic [8:0]         sden_s3;
	logic [16:0]        lx_s3;
	logic [F:0]         lb_s3;
	logic [16:0]        shp_c;

	assign shp_c = 17'(hue_q) * 17'(dd_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		np_s3   <= {{7{num_s2[11]}}, num_s2} * 19'sd60 + $signed({2'b0, shp_c});
		d_s3    <= 17'(dd_s2) * 17'(hsla_pkg::DEG_TURN);
		snum_s3 <= delta_s2;
		if (delta_s2 == 8'd0)
			sden_s3 <= 9'd1;
		else if (sum_s2 < 9'd255)
			sden_s3 <= sum_s2;
		else
			sden_s3 <= 9'd510 - sum_s2;
		lx_s3  <= 17'(sum_s2) * 17'(L_RA);
		lb_s3  <= (F+1)'(sum_s2) * L_QA;
		a_s3   <= a_s2;
	end

	// s4: wrap the hue numerator into one turn, estimate lightness remainder quotient
	logic               vld_s4;
	logic signed [18:0] ds_c, t_c;
	logic [16:0]        t_s4, d_s4;
	logic [7:0]         snum_s4, a_s4;
	logic [8:0]         sden_s4;
	logic [24:0]        lr_c;
	logic [8:0]         lq0_s4;
	logic [16:0]        lx_s4;
	logic [F:0]         lb_s4;

	always_comb begin
		ds_c = $signed({2'b0, d_s3});
		if (np_s3 < 0)         t_c = np_s3 + ds_c;
		else if (np_s3 >= ds_c) t_c = np_s3 - ds_c;
		else                   t_c = np_s3;
	end

	// x * 257 / 2^16 is x / 255 or one below it
	assign lr_c = 25'(lx_s3) * 25'(257);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		t_s4    <= t_c[16:0];
		d_s4    <= d_s3;
		snum_s4 <= snum_s3;
		sden_s4 <= sden_s3;
		lq0_s4  <= lr_c[24:16];
		lx_s4   <= lx_s3;
		lb_s4   <= lb_s3;
		a_s4    <= a_s3;
	end

	// dividers for hue and saturation
	logic [QB-1:0] hq, sq;

	hsla_div #(.QB(QB), .DW(17)) u_div_hue (
		.clk(clk), .numer({1'b0, t_s4}), .denom(d_s4), .quot(hq), .rem_nz()
	);

	hsla_div #(.QB(QB), .DW(9)) u_div_sat (
		.clk(clk), .numer({2'b0, snum_s4}), .denom(sden_s4), .quot(sq), .rem_nz()
	);

	// lightness: correct the quotient estimate, round up, then wait for the dividers
	logic [16:0] lrem_c;
	logic        lge_c;
	logic [8:0]  lq_c;
	logic        lnz_c;
	logic [F:0]  lt_c;
	logic [F:0]  lt_dl_q [QB];

	always_comb begin
		lrem_c = lx_s4 - 17'(lq0_s4) * 17'(255);
		lge_c  = lrem_c >= 17'd255;
		lq_c   = lq0_s4 + 9'(lge_c);
		lnz_c  = lge_c ? (lrem_c != 17'd255) : (lrem_c != 17'd0);
		lt_c   = lb_s4 + (F+1)'(lq_c) + (F+1)'(lnz_c);
	end

	always_ff @(posedge clk) begin
		lt_dl_q[0] <= lt_c;
		for (int i = 1; i < QB; i++) lt_dl_q[i] <= lt_dl_q[i-1];
	end

	// valid and alpha ride alongside the dividers and back stages
	logic       vld_dl_q   [DL];
	logic [7:0] alpha_dl_q [DL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) vld_dl_q[i] <= 1'b0;
		end else begin
			vld_dl_q[0] <= vld_s4;
			for (int i = 1; i < DL; i++) vld_dl_q[i] <= vld_dl_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		alpha_dl_q[0] <= a_s4;
		for (int i = 1; i < DL; i++) alpha_dl_q[i] <= alpha_dl_q[i-1];
	end

	// p1: saturation offset and clamp, lightness taken from its delay line
	logic signed [F+2:0] so_c;
	logic [F:0]          s_p1, l_p1;
	logic [F-1:0]        h_p1;

	assign so_c = $signed({2'b0, sq}) + ($signed({{(F-7){sat_q[9]}}, sat_q}) <<< (F - 8));

	always_ff @(posedge clk) begin
		if (so_c < 0)                          s_p1 <= '0;
		else if (so_c > $signed({2'b0, ONE})) s_p1 <= ONE;
		else                                   s_p1 <= so_c[F:0];
		l_p1 <= lt_dl_q[QB-1];
		h_p1 <= hq[F-1:0];
	end

	// p2: lightness gain product
	logic [F+11:0] lg_p2;
	logic [F:0]    s_p2;
	logic [F-1:0]  h_p2;

	always_ff @(posedge clk) begin
		lg_p2 <= (F+12)'(l_p1) * (F+12)'(gain_q);
		s_p2  <= s_p1;
		h_p2  <= h_p1;
	end

	// p3: lightness clamp to one
	logic [F+3:0] lsh_c;
	logic [F:0]   s_p3, l_p3;
	logic [F-1:0] h_p3;

	assign lsh_c = lg_p2[F+11:8];

	always_ff @(posedge clk) begin
		l_p3 <= (lsh_c > (F+4)'(ONE)) ? ONE : lsh_c[F:0];
		s_p3 <= s_p2;
		h_p3 <= h_p2;
	end

	// p4: saturation times lightness
	logic [2*F+1:0] pr_p4;
	logic [F:0]     s_p4, l_p4;
	logic [F-1:0]   h_p4;

	always_ff @(posedge clk) begin
		pr_p4 <= (2*F+2)'(s_p3) * (2*F+2)'(l_p3);
		s_p4  <= s_p3;
		l_p4  <= l_p3;
		h_p4  <= h_p3;
	end

	// p5: v1, v2 and the three channel hues
	logic [F+1:0]        pf_c, v2_c;
	logic signed [F+2:0] v1_c;
	logic [F:0]          hr_c;
	logic [F+1:0]        v1_p5, v2_p5;
	logic [F:0]          l_p5;
	logic                grey_p5;
	logic [F-1:0]        vh_p5 [3];

	always_comb begin
		pf_c = pr_p4[2*F+1:F];
		if ({l_p4, 1'b0} < {1'b0, ONE}) v2_c = {1'b0, l_p4} + pf_c;
		else v2_c = {1'b0, l_p4} + {1'b0, s_p4} - pf_c;
		v1_c = $signed({1'b0, l_p4, 1'b0}) - $signed({1'b0, v2_c});
		hr_c = {1'b0, h_p4} + {1'b0, THIRD};
	end

	always_ff @(posedge clk) begin
		v2_p5   <= v2_c;
		v1_p5   <= (v1_c < 0) ? '0 : v1_c[F+1:0];
		l_p5    <= l_p4;
		grey_p5 <= (s_p4 == '0);
		vh_p5[0] <= (hr_c >= ONE) ? F'(hr_c - ONE) : hr_c[F-1:0];
		vh_p5[1] <= h_p4;
		vh_p5[2] <= (h_p4 >= THIRD) ? h_p4 - THIRD : h_p4 + TWO_THIRD;
	end

	// p6: per channel sector and ramp factor
	logic [F+1:0]        v1_p6, v2_p6, diff_p6;
	logic [F:0]          l_p6;
	logic                grey_p6;
	hsla_pkg::sector_t   sec_p6 [3];
	logic [F+2:0]        fac_p6 [3];

	for (genvar c = 0; c < 3; c++) begin : g_sec
		logic [F+2:0] six;
		logic [F+2:0] three;

		assign six   = (F+3)'(vh_p5[c]) * (F+3)'(6);
		assign three = (F+3)'(vh_p5[c]) * (F+3)'(3);

		always_ff @(posedge clk) begin
			if (six < (F+3)'(ONE)) begin
				sec_p6[c] <= hsla_pkg::SEC_RISE;
				fac_p6[c] <= six;
			end else if ({vh_p5[c], 1'b0} < (F+1)'(ONE)) begin
				sec_p6[c] <= hsla_pkg::SEC_HIGH;
				fac_p6[c] <= '0;
			end else if (three < (F+3)'({ONE, 1'b0})) begin
				sec_p6[c] <= hsla_pkg::SEC_FALL;
				fac_p6[c] <= (F+3)'({ONE, 2'b0}) - six;
			end else begin
				sec_p6[c] <= hsla_pkg::SEC_LOW;
				fac_p6[c] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		diff_p6 <= v2_p5 - v1_p5;
		v1_p6   <= v1_p5;
		v2_p6   <= v2_p5;
		l_p6    <= l_p5;
		grey_p6 <= grey_p5;
	end

	// p7: ramp products
	logic [2*F+4:0]    prod_p7 [3];
	hsla_pkg::sector_t sec_p7  [3];
	logic [F+1:0]      v1_p7, v2_p7;
	logic [F:0]        l_p7;
	logic              grey_p7;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			prod_p7[c] <= (2*F+5)'(diff_p6) * (2*F+5)'(fac_p6[c]);
			sec_p7[c]  <= sec_p6[c];
		end
		v1_p7   <= v1_p6;
		v2_p7   <= v2_p6;
		l_p7    <= l_p6;
		grey_p7 <= grey_p6;
	end

	// p8: channel value in the unit range
	logic [F+1:0] val_p8 [3];

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (grey_p7) begin
				val_p8[c] <= {1'b0, l_p7};
			end else begin
				case (sec_p7[c])
					hsla_pkg::SEC_RISE,
					hsla_pkg::SEC_FALL: val_p8[c] <= v1_p7 + prod_p7[c][F+F+1:F];
					hsla_pkg::SEC_HIGH: val_p8[c] <= v2_p7;
					hsla_pkg::SEC_LOW:  val_p8[c] <= v1_p7;
					default:            val_p8[c] <= v1_p7;
				endcase
			end
		end
	end

	// p9: scale to 8 bits and register the outputs
	logic [F+9:0] sc_c [3];
	logic [7:0]   ch_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sc_c[c] = ({val_p8[c], 8'b0} - (F+10)'(val_p8[c])) >> F;
			ch_c[c] = (sc_c[c] > (F+10)'(hsla_pkg::CH_MAX)) ? hsla_pkg::CH_MAX : sc_c[c][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else         strobe <= vld_dl_q[DL-1];
	end

	always_ff @(posedge clk) begin
		out_red   <= ch_c[0];
		out_green <= ch_c[1];
		out_blue  <= ch_c[2];
		out_alpha <= alpha_dl_q[DL-1];
	end

endmodule

@@ rtl/hsla_chk.sv @@
// port-level checks for the rgb/hsl color adjust block, bound to its top level
// depends on rgb_hsl_color_adjust port names and its FRAC_BITS parameter only
module hsla_chk #(
	parameter int FRAC_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [7:0] in_alpha,
	input logic       strobe,
	input logic [7:0] out_alpha
);

	localparam int LAT = FRAC_BITS + 14;

	// every taken item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT strobe)
		else $error("item did not come out after fixed latency");

	// no result without an item taken earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, LAT))
		else $error("result without a matching item");

	// alpha travels with its pixel
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (out_alpha == $past(in_alpha, LAT)))
		else $error("alpha does not match its pixel");

endmodule

bind rgb_hsl_color_adjust hsla_chk #(.FRAC_BITS(FRAC_BITS)) u_hsla_chk (.*);
